// File: hw/rtl/pva_pkg.sv
// Shared types and constants for the pixel vibrance adjust pipeline.
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

   localparam int CHAN_W       = 8;
   localparam int NUM_CHAN     = 3;
   localparam int VIB_W        = 16;
   localparam int VIB_FRAC     = 8;
   localparam int DIV_W        = 10;
   localparam int DIFF_W       = 11;
   localparam int SAT_X        = 768;
   localparam int RECIP3       = 683;
   localparam int RECIP3_SHIFT = 11;
   localparam int RECIP_PROD_W = 20;

   localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;
   localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } pva_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
   } pva_rsp_type;

   typedef struct packed {
      pva_req_type      pixel;
      logic [DIV_W-1:0] sum;
      logic             pass;
   } pva_side_type;

endpackage

`default_nettype wire

// File: hw/rtl/pva_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module pva_divider #(
   parameter int QUO_W = 26
) (
   input  wire logic                         clock,
   input  wire logic [QUO_W-1:0]             stage_en,
   input  wire logic [pva_pkg::DIV_W-1:0]    num,
   input  wire logic [pva_pkg::DIV_W-1:0]    den,
   output logic      [QUO_W-1:0]             quo
);

   logic [pva_pkg::DIV_W-1:0] rem_ff [QUO_W-1];
   logic [pva_pkg::DIV_W-1:0] num_ff [pva_pkg::DIV_W-1];
   logic [pva_pkg::DIV_W-1:0] den_ff [QUO_W-1];
   logic [QUO_W-1:0]          quo_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic [pva_pkg::DIV_W-1:0] rem_prev;
      logic [pva_pkg::DIV_W-1:0] den_prev;
      logic [QUO_W-1:0]          quo_prev;
      logic                      next_bit;
      logic [pva_pkg::DIV_W:0]   trial;
      logic                      fits;
      logic [QUO_W-1:0]          quo_in;

      if (j == 0) begin : g_first
         assign rem_prev = '0;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      if (j < pva_pkg::DIV_W) begin : g_num_bit
         logic [pva_pkg::DIV_W-1:0] num_prev;

         if (j == 0) begin : g_num_first
            assign num_prev = num;
         end else begin : g_num_next
            assign num_prev = num_ff[j-1];
         end

         assign next_bit = num_prev[pva_pkg::DIV_W-1-j];

         if (j < pva_pkg::DIV_W - 1) begin : g_num_carry
            always_ff @(posedge clock) begin
               if (stage_en[j]) begin
                  num_ff[j] <= num_prev;
               end
            end
         end
      end else begin : g_zero_bit
         assign next_bit = 1'b0;
      end

      assign trial  = {rem_prev, next_bit};
      assign fits   = (trial >= {1'b0, den_prev});
      assign quo_in = {quo_prev[QUO_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            quo_ff[j] <= quo_in;
         end
      end

      if (j < QUO_W - 1) begin : g_carry
         logic [pva_pkg::DIV_W-1:0] rem_in;

         assign rem_in = fits ? pva_pkg::DIV_W'(trial - {1'b0, den_prev})
                              : trial[pva_pkg::DIV_W-1:0];

         always_ff @(posedge clock) begin
            if (stage_en[j]) begin
               rem_ff[j] <= rem_in;
               den_ff[j] <= den_prev;
            end
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

`default_nettype wire

// File: hw/rtl/pixel_vibrance_adjust_top.sv
// Pixel vibrance adjust: top level with the full processing pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Takes one RGB pixel per clock and returns the vibrance-adjusted pixel, one
// per clock, in order, while the result side does not stall. The two
// pipelined dividers (min/max and the gain limit) produce one quotient bit
// per stage over FRAC_BITS + 10 stages. Each stage moves when the next one
// is empty or moving, so bubbles collapse and a stall on the result side
// holds every beat in place. Grey pixels and pixels with a zero channel pass
// through unchanged. Write csr_write_data only while the pipeline is empty;
// it is used by every pixel that follows.
module pixel_vibrance_adjust_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire pva_pkg::pva_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pva_pkg::pva_rsp_type      rsp_data,
   input  wire logic                 csr_write_en,
   input  wire logic [pva_pkg::VIB_W-1:0] csr_write_data
);

   localparam int CW    = pva_pkg::CHAN_W;
   localparam int DW    = pva_pkg::DIV_W;
   localparam int QW    = FRAC_BITS + DW;
   localparam int GW    = QW + 1;
   localparam int PW    = FRAC_BITS + 1 + GW;
   localparam int CPW   = pva_pkg::DIFF_W + GW;
   localparam int NW    = CPW + 1;
   localparam int XW    = NW - FRAC_BITS;
   localparam int RW    = pva_pkg::RECIP_PROD_W;

   localparam int ST_IN  = 0;
   localparam int ST_PRE = 1;
   localparam int ST_D0  = 2;
   localparam int ST_G   = QW + 2;
   localparam int ST_M   = QW + 3;
   localparam int ST_N   = QW + 4;
   localparam int ST_P   = QW + 5;
   localparam int ST_Q   = QW + 6;
   localparam int NS     = QW + 7;

   // configuration
   logic signed [pva_pkg::VIB_W-1:0] vibrance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vibrance_ff <= '0;
      end else if (csr_write_en) begin
         vibrance_ff <= csr_write_data;
      end
   end

   // stage flow control
   logic [NS-1:0] valid_ff;
   logic [NS:0]   adv;

   assign adv[NS] = rsp_ready;
   for (genvar i = 0; i < NS; i++) begin : g_adv
      assign adv[i] = !valid_ff[i] || adv[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[ST_IN]) begin
            valid_ff[ST_IN] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_ready = adv[ST_IN];
   assign rsp_valid = valid_ff[ST_Q];

   // stage 0: max, min, sum
   logic [CW-1:0]       mx_in, mn_in;
   logic [DW-1:0]       sum_in;
   pva_pkg::pva_req_type px0_ff;
   logic [CW-1:0]       mx0_ff, mn0_ff;
   logic [DW-1:0]       sum0_ff;

   always_comb begin
      mx_in = req_data.red_in;
      mn_in = req_data.red_in;
      if (req_data.green_in > mx_in) mx_in = req_data.green_in;
      if (req_data.green_in < mn_in) mn_in = req_data.green_in;
      if (req_data.blue_in > mx_in) mx_in = req_data.blue_in;
      if (req_data.blue_in < mn_in) mn_in = req_data.blue_in;
      sum_in = DW'(req_data.red_in) + DW'(req_data.green_in) + DW'(req_data.blue_in);
   end

   always_ff @(posedge clock) begin
      if (adv[ST_IN]) begin
         px0_ff  <= req_data;
         mx0_ff  <= mx_in;
         mn0_ff  <= mn_in;
         sum0_ff <= sum_in;
      end
   end

   // stage 1: divider operands, pass-through decision
   pva_pkg::pva_side_type side1_in, side1_ff;
   logic [DW-1:0]         num_sig_ff, den_sig_ff, num_lim_ff, den_lim_ff;

   assign side1_in.pixel = px0_ff;
   assign side1_in.sum   = sum0_ff;
   assign side1_in.pass  = (mx0_ff == mn0_ff) || (mn0_ff == pva_pkg::CHAN_ZERO);

   always_ff @(posedge clock) begin
      if (adv[ST_PRE]) begin
         side1_ff   <= side1_in;
         num_sig_ff <= DW'(mn0_ff);
         den_sig_ff <= DW'(mx0_ff);
         num_lim_ff <= DW'(3) * DW'(mx0_ff);
         den_lim_ff <= sum0_ff - DW'(3) * DW'(mn0_ff);
      end
   end

   // divider stages
   logic [QW-1:0]         quo_sig, quo_lim;
   pva_pkg::pva_side_type side_ff [QW];

   pva_divider #(
      .QUO_W(QW)
   ) u_div_sigma (
      .clock    (clock),
      .stage_en (adv[ST_D0 +: QW]),
      .num      (num_sig_ff),
      .den      (den_sig_ff),
      .quo      (quo_sig)
   );

   pva_divider #(
      .QUO_W(QW)
   ) u_div_limit (
      .clock    (clock),
      .stage_en (adv[ST_D0 +: QW]),
      .num      (num_lim_ff),
      .den      (den_lim_ff),
      .quo      (quo_lim)
   );

   always_ff @(posedge clock) begin
      if (adv[ST_D0]) begin
         side_ff[0] <= side1_ff;
      end
      for (int j = 1; j < QW; j++) begin
         if (adv[ST_D0 + j]) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // stage G: cap the gain at the limit
   logic signed [GW-1:0]   vib_q, lim_ext, gain_in;
   pva_pkg::pva_side_type  sideg_ff;
   logic [FRAC_BITS-1:0]   sigma_g_ff;
   logic signed [GW-1:0]   gain_g_ff;

   assign vib_q   = GW'(vibrance_ff) <<< (FRAC_BITS - pva_pkg::VIB_FRAC);
   assign lim_ext = $signed({1'b0, quo_lim});
   assign gain_in = (vib_q >= lim_ext) ? lim_ext : vib_q;

   always_ff @(posedge clock) begin
      if (adv[ST_G]) begin
         sideg_ff   <= side_ff[QW-1];
         sigma_g_ff <= quo_sig[FRAC_BITS-1:0];
         gain_g_ff  <= gain_in;
      end
   end

   // stage M: sigma * gain
   pva_pkg::pva_side_type sidem_ff;
   logic signed [PW-1:0]  prod_m_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_M]) begin
         sidem_ff  <= sideg_ff;
         prod_m_ff <= $signed({1'b0, sigma_g_ff}) * gain_g_ff;
      end
   end

   // stage N: (3c - sum) * sg per channel
   logic signed [GW-1:0]  sg;
   logic [CW-1:0]         chan_m [pva_pkg::NUM_CHAN];
   pva_pkg::pva_side_type siden_ff;
   logic signed [CPW-1:0] dprod_ff [pva_pkg::NUM_CHAN];

   assign sg        = $signed(prod_m_ff[FRAC_BITS+GW-1:FRAC_BITS]);
   assign chan_m[0] = sidem_ff.pixel.red_in;
   assign chan_m[1] = sidem_ff.pixel.green_in;
   assign chan_m[2] = sidem_ff.pixel.blue_in;

   for (genvar c = 0; c < pva_pkg::NUM_CHAN; c++) begin : g_diff
      logic signed [pva_pkg::DIFF_W-1:0] diff;

      assign diff = $signed({1'b0, DW'(3) * DW'(chan_m[c])}) - $signed({1'b0, sidem_ff.sum});

      always_ff @(posedge clock) begin
         if (adv[ST_N]) begin
            dprod_ff[c] <= diff * sg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_N]) begin
         siden_ff <= sidem_ff;
      end
   end

   // stage P: add the scaled channel
   logic [CW-1:0]         chan_n [pva_pkg::NUM_CHAN];
   pva_pkg::pva_side_type sidep_ff;
   logic signed [NW-1:0]  n_ff [pva_pkg::NUM_CHAN];

   assign chan_n[0] = siden_ff.pixel.red_in;
   assign chan_n[1] = siden_ff.pixel.green_in;
   assign chan_n[2] = siden_ff.pixel.blue_in;

   for (genvar c = 0; c < pva_pkg::NUM_CHAN; c++) begin : g_sum
      logic signed [NW-1:0] base;

      assign base = $signed(NW'(DW'(3) * DW'(chan_n[c])) << FRAC_BITS);

      always_ff @(posedge clock) begin
         if (adv[ST_P]) begin
            n_ff[c] <= base + NW'(dprod_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_P]) begin
         sidep_ff <= siden_ff;
      end
   end

   // stage Q: divide by 3 << FRAC_BITS, saturate, select pass-through
   logic [CW-1:0]        res_q [pva_pkg::NUM_CHAN];
   pva_pkg::pva_rsp_type rsp_in, rsp_ff;

   for (genvar c = 0; c < pva_pkg::NUM_CHAN; c++) begin : g_sat
      logic [XW-1:0] x;
      logic [RW-1:0] recip;

      assign x     = n_ff[c][NW-1:FRAC_BITS];
      assign recip = RW'(x[DW-1:0]) * RW'(pva_pkg::RECIP3);

      always_comb begin
         priority if (n_ff[c][NW-1]) begin
            res_q[c] = pva_pkg::CHAN_ZERO;
         end else if (x >= XW'(pva_pkg::SAT_X)) begin
            res_q[c] = pva_pkg::CHAN_MAX;
         end else begin
            res_q[c] = recip[pva_pkg::RECIP3_SHIFT +: CW];
         end
      end
   end

   always_comb begin
      if (sidep_ff.pass) begin
         rsp_in.red_out   = sidep_ff.pixel.red_in;
         rsp_in.green_out = sidep_ff.pixel.green_in;
         rsp_in.blue_out  = sidep_ff.pixel.blue_in;
      end else begin
         rsp_in.red_out   = res_q[0];
         rsp_in.green_out = res_q[1];
         rsp_in.blue_out  = res_q[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_Q]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire
